// ----- hw/rtl/dmr_pkg.sv -----
// shared types, codes and constants for the motor duty ramp driver
`default_nettype none
package dmr_pkg;

  localparam logic [9:0] FULL_SCALE = 10'd1000;
  localparam int         ADDR_W     = 5;

  // operation codes
  localparam logic [1:0] OP_DIRECT = 2'd0;
  localparam logic [1:0] OP_RAMP   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // direction codes
  localparam logic [1:0] DIR_BRAKE = 2'd0;
  localparam logic [1:0] DIR_FWD   = 2'd1;
  localparam logic [1:0] DIR_BACK  = 2'd2;
  localparam logic [1:0] DIR_BAD   = 2'd3;

  // register indexes
  localparam logic [2:0] REG_UP_STEP   = 3'd0;
  localparam logic [2:0] REG_DOWN_STEP = 3'd1;
  localparam logic [2:0] REG_FAST      = 3'd2;
  localparam logic [2:0] REG_THRESHOLD = 3'd3;
  localparam logic [2:0] REG_STOP_CODE = 3'd4;

  typedef struct packed {
    logic [1:0] operation;
    logic [1:0] channel;
    logic [9:0] target_duty;
    logic [1:0] target_dir;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0] out_channel;
    logic       dir_pin;
    logic [9:0] pwm_level;
    logic [9:0] applied_duty;
    logic [1:0] applied_dir;
  } res_item_t;

  typedef struct packed {
    logic [9:0] up_step;
    logic [9:0] down_step;
    logic [3:0] fast_factor;
    logic [9:0] switch_threshold;
    logic [9:0] stop_code;
  } cfg_t;

endpackage
`default_nettype wire

// ----- hw/rtl/dmr_cfg.sv -----
// configuration register file behind the apb-style port
`default_nettype none
module dmr_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [dmr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output dmr_pkg::cfg_t                   cfg
);

  logic [2:0] index;
  logic       wr;

  assign index = paddr[4:2];
  assign wr    = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.up_step          <= 10'd10;
      cfg.down_step        <= 10'd10;
      cfg.fast_factor      <= 4'd2;
      cfg.switch_threshold <= 10'd50;
      cfg.stop_code        <= 10'd0;
    end else if (wr) begin
      case (index)
        dmr_pkg::REG_UP_STEP:   cfg.up_step          <= pwdata[9:0];
        dmr_pkg::REG_DOWN_STEP: cfg.down_step        <= pwdata[9:0];
        dmr_pkg::REG_FAST:      cfg.fast_factor      <= pwdata[3:0];
        dmr_pkg::REG_THRESHOLD: cfg.switch_threshold <= pwdata[9:0];
        dmr_pkg::REG_STOP_CODE: cfg.stop_code        <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      dmr_pkg::REG_UP_STEP:   prdata = {22'd0, cfg.up_step};
      dmr_pkg::REG_DOWN_STEP: prdata = {22'd0, cfg.down_step};
      dmr_pkg::REG_FAST:      prdata = {28'd0, cfg.fast_factor};
      dmr_pkg::REG_THRESHOLD: prdata = {22'd0, cfg.switch_threshold};
      dmr_pkg::REG_STOP_CODE: prdata = {22'd0, cfg.stop_code};
      default:                prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/dmr_ramp.sv -----
// per-channel duty and direction state with the ramp update and pin mapping
`default_nettype none
module dmr_ramp #(
  parameter int CHANNELS = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dmr_pkg::cfg_t       cfg,
  input  wire dmr_pkg::cmd_item_t  item,
  input  wire logic                fire,
  output logic                     has_result,
  output dmr_pkg::res_item_t       res
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [9:0] current_duty [CHANNELS];
  logic [1:0] current_dir  [CHANNELS];

  logic [IDX_W-1:0] idx;
  logic [9:0]  tduty, old_duty, duty_next, out_duty, lvl_duty;
  logic [1:0]  tdir, old_dir, dir_next, out_dir, plain_dir;
  logic [13:0] fast;
  logic [9:0]  fast_sub, down_sub;
  logic [10:0] up_sum;
  logic        in_range;

  assign idx      = IDX_W'(item.channel);
  assign in_range = 32'(item.channel) < CHANNELS;
  assign has_result = in_range && (item.operation != dmr_pkg::OP_NONE);

  assign old_duty = current_duty[idx];
  assign old_dir  = current_dir[idx];

  assign tduty = (item.target_duty > dmr_pkg::FULL_SCALE) ? dmr_pkg::FULL_SCALE
                                                          : item.target_duty;
  assign tdir  = (item.target_dir == dmr_pkg::DIR_BAD) ? dmr_pkg::DIR_BRAKE
                                                       : item.target_dir;

  assign fast     = 14'(cfg.down_step) * 14'(cfg.fast_factor);
  assign fast_sub = (14'(old_duty) > fast) ? 10'(14'(old_duty) - fast) : 10'd0;
  assign up_sum   = {1'b0, old_duty} + {1'b0, cfg.up_step};

  always_comb begin
    down_sub = (old_duty > cfg.down_step) ? old_duty - cfg.down_step : 10'd0;
    if (down_sub < tduty) begin
      down_sub = tduty;
    end
  end

  // ramp update for the addressed channel
  always_comb begin
    duty_next = old_duty;
    dir_next  = old_dir;
    case (item.operation)
      dmr_pkg::OP_CLEAR: begin
        duty_next = 10'd0;
        dir_next  = dmr_pkg::DIR_BRAKE;
      end
      dmr_pkg::OP_RAMP: begin
        if (item.target_duty == cfg.stop_code) begin
          duty_next = fast_sub;
        end else if (tdir == old_dir) begin
          if (tduty > old_duty) begin
            duty_next = (up_sum > {1'b0, tduty}) ? tduty : up_sum[9:0];
          end else begin
            duty_next = down_sub;
          end
        end else begin
          // reversal: brake hard, adopt new direction only when slow
          duty_next = fast_sub;
          if (fast_sub < cfg.switch_threshold) begin
            dir_next = tdir;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        current_duty[i] <= 10'd0;
        current_dir[i]  <= dmr_pkg::DIR_BRAKE;
      end
    end else if (fire && has_result) begin
      current_duty[idx] <= duty_next;
      current_dir[idx]  <= dir_next;
    end
  end

  // output mapping
  always_comb begin
    if (item.operation == dmr_pkg::OP_DIRECT) begin
      out_duty = tduty;
      out_dir  = tdir;
    end else begin
      out_duty = duty_next;
      out_dir  = dir_next;
    end
    lvl_duty  = (out_duty > dmr_pkg::FULL_SCALE) ? dmr_pkg::FULL_SCALE : out_duty;
    plain_dir = item.channel[0] ? dmr_pkg::DIR_FWD : dmr_pkg::DIR_BACK;

    res.out_channel  = item.channel;
    res.applied_duty = duty_next;
    res.applied_dir  = dir_next;
    if (out_dir == dmr_pkg::DIR_BRAKE) begin
      res.dir_pin   = 1'b1;
      res.pwm_level = dmr_pkg::FULL_SCALE;
    end else if (out_dir == plain_dir) begin
      res.dir_pin   = 1'b0;
      res.pwm_level = lvl_duty;
    end else begin
      res.dir_pin   = 1'b1;
      res.pwm_level = dmr_pkg::FULL_SCALE - lvl_duty;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/motor_duty_ramp_driver.sv -----
// motor duty ramp driver top level: item register, ramp logic, result register
//
//   channel   direction  handshake                     payload
//   cmd       in         cmd_valid / cmd_ready         cmd (dmr_pkg::cmd_item_t)
//   res       out        res_valid / res_ready         res (dmr_pkg::res_item_t)
//   config    in         psel penable pwrite pready    paddr pwdata / prdata
//
// one item per cycle unless a stalled result holds the item back; a result is registered
// after its item is accepted (item register, single ramp pass, result register).
// items with operation 3 or a channel at or above CHANNELS give no result.
// reset clears all channels to zero duty and brake and loads register defaults.
// a stalled result holds the result register; the item register keeps
// taking items as long as its content can move on.
`default_nettype none
module motor_duty_ramp_driver #(
  parameter int CHANNELS = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cmd_valid,
  output logic                            cmd_ready,
  input  wire dmr_pkg::cmd_item_t         cmd,
  output logic                            res_valid,
  input  wire logic                       res_ready,
  output dmr_pkg::res_item_t              res,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [dmr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready
);

  dmr_pkg::cfg_t      cfg;
  dmr_pkg::cmd_item_t item;
  dmr_pkg::res_item_t ramp_res;
  logic               item_valid;
  logic               has_result;
  logic               advance;

  assign pready = 1'b1;

  dmr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  dmr_ramp #(
    .CHANNELS (CHANNELS)
  ) u_ramp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (item),
    .fire       (advance),
    .has_result (has_result),
    .res        (ramp_res)
  );

  // item leaves the item register when its result has room or it has none
  assign advance   = item_valid && (!has_result || !res_valid || res_ready);
  assign cmd_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (cmd_valid && cmd_ready) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      item <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && has_result) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      res <= ramp_res;
    end
  end

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (advance && has_result) |=> res_valid)
    else $error("result lost after item left the item register");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (advance && has_result && item.operation == dmr_pkg::OP_CLEAR) |=>
    (res.applied_duty == 10'd0 && res.applied_dir == dmr_pkg::DIR_BRAKE &&
     res.dir_pin && res.pwm_level == dmr_pkg::FULL_SCALE))
    else $error("clear item did not give brake at zero duty");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.pwm_level <= dmr_pkg::FULL_SCALE &&
                   res.applied_duty <= dmr_pkg::FULL_SCALE))
    else $error("duty or level beyond full scale");
`endif

endmodule
`default_nettype wire

// ----- bench/ramp_result_checker.sv -----
// result checker for the motor duty ramp driver: mirrors the ramp state and compares results
`timescale 1ns / 1ps
module ramp_result_checker #(
  parameter int CHANNELS = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  input  logic                       cmd_ready,
  input  dmr_pkg::cmd_item_t         cmd,
  input  logic                       res_valid,
  input  logic                       res_ready,
  input  dmr_pkg::res_item_t         res,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [dmr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output int                         results_due,
  output int                         fail_count
);
  import dmr_pkg::*;

  cfg_t       cfg;
  logic [9:0] duty_mirror [CHANNELS];
  logic [1:0] dir_mirror  [CHANNELS];
  res_item_t  due_results [$];

  task automatic note_fail(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  function automatic int floor_sub(input int a, input int b, input int lo);
    int d;
    d = (a > b) ? a - b : 0;
    return (d < lo) ? lo : d;
  endfunction

  // one item through the channel ramp, updating the mirrored state
  function automatic res_item_t predict_drive(input cmd_item_t c);
    res_item_t  r;
    int         ch, raw, tduty, old, fast, nd, show_duty;
    logic [1:0] tdir, odir, show_dir, plain;
    ch    = int'(c.channel);
    raw   = int'(c.target_duty);
    tduty = (raw > int'(FULL_SCALE)) ? int'(FULL_SCALE) : raw;
    tdir  = (c.target_dir == DIR_BAD) ? DIR_BRAKE : c.target_dir;
    if (c.operation == OP_DIRECT) begin
      show_duty = tduty;
      show_dir  = tdir;
    end else if (c.operation == OP_CLEAR) begin
      duty_mirror[ch] = '0;
      dir_mirror[ch]  = DIR_BRAKE;
      show_duty       = 0;
      show_dir        = DIR_BRAKE;
    end else begin
      old  = int'(duty_mirror[ch]);
      odir = dir_mirror[ch];
      fast = int'(cfg.down_step) * int'(cfg.fast_factor);
      if (raw == int'(cfg.stop_code)) begin
        nd = floor_sub(old, fast, 0);
      end else if (tdir == odir) begin
        if (tduty > old) begin
          nd = old + int'(cfg.up_step);
          if (nd > tduty) nd = tduty;
        end else begin
          nd = floor_sub(old, int'(cfg.down_step), tduty);
        end
      end else begin
        // reversal: brake hard, adopt the new direction only once slow enough
        nd = floor_sub(old, fast, 0);
        if (nd < int'(cfg.switch_threshold)) dir_mirror[ch] = tdir;
      end
      duty_mirror[ch] = 10'(nd);
      show_duty       = nd;
      show_dir        = dir_mirror[ch];
    end
    plain = c.channel[0] ? DIR_FWD : DIR_BACK;
    r.out_channel = c.channel;
    if (show_dir == DIR_BRAKE) begin
      r.dir_pin   = 1'b1;
      r.pwm_level = FULL_SCALE;
    end else if (show_dir == plain) begin
      r.dir_pin   = 1'b0;
      r.pwm_level = 10'(show_duty);
    end else begin
      r.dir_pin   = 1'b1;
      r.pwm_level = 10'(int'(FULL_SCALE) - show_duty);
    end
    r.applied_duty = duty_mirror[ch];
    r.applied_dir  = dir_mirror[ch];
    return r;
  endfunction

  always @(posedge clk) begin
    res_item_t want;
    if (rst) begin
      cfg.up_step          = 10'd10;
      cfg.down_step        = 10'd10;
      cfg.fast_factor      = 4'd2;
      cfg.switch_threshold = 10'd50;
      cfg.stop_code        = 10'd0;
      for (int i = 0; i < CHANNELS; i++) begin
        duty_mirror[i] = '0;
        dir_mirror[i]  = DIR_BRAKE;
      end
      due_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_UP_STEP:   cfg.up_step          = pwdata[9:0];
          REG_DOWN_STEP: cfg.down_step        = pwdata[9:0];
          REG_FAST:      cfg.fast_factor      = pwdata[3:0];
          REG_THRESHOLD: cfg.switch_threshold = pwdata[9:0];
          REG_STOP_CODE: cfg.stop_code        = pwdata[9:0];
          default: ;
        endcase
      end
      if (cmd_valid && cmd_ready) begin
        if (cmd.operation != OP_NONE && int'(cmd.channel) < CHANNELS)
          due_results.push_back(predict_drive(cmd));
      end
      if (res_valid && res_ready) begin
        if (due_results.size() == 0) begin
          note_fail($sformatf("result with nothing expected: %h", res));
        end else begin
          want = due_results.pop_front();
          if (res.out_channel !== want.out_channel)
            note_fail($sformatf("out_channel %h, want %h", res.out_channel, want.out_channel));
          if (res.dir_pin !== want.dir_pin)
            note_fail($sformatf("ch %0d dir_pin %b, want %b",
                                want.out_channel, res.dir_pin, want.dir_pin));
          if (res.pwm_level !== want.pwm_level)
            note_fail($sformatf("ch %0d pwm_level %0d, want %0d",
                                want.out_channel, res.pwm_level, want.pwm_level));
          if (res.applied_duty !== want.applied_duty)
            note_fail($sformatf("ch %0d applied_duty %0d, want %0d",
                                want.out_channel, res.applied_duty, want.applied_duty));
          if (res.applied_dir !== want.applied_dir)
            note_fail($sformatf("ch %0d applied_dir %0d, want %0d",
                                want.out_channel, res.applied_dir, want.applied_dir));
        end
      end
    end
    results_due <= due_results.size();
  end

endmodule

// ----- bench/tb_motor_duty_ramp_driver.sv -----
// testbench top for the motor duty ramp driver: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb_motor_duty_ramp_driver;
  import dmr_pkg::*;

  localparam int N_CH = 4;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cmd_valid = 1'b0;
  logic              cmd_ready;
  cmd_item_t         cmd       = '0;
  logic              res_valid;
  logic              res_ready = 1'b1;
  res_item_t         res;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [31:0]       pwdata    = '0;
  logic [31:0]       prdata;
  logic              pready;
  int                results_due;
  int                fail_count;

  int         idle_pct = 0;
  logic [9:0] stop_now = 10'd0;
  logic [9:0] goal_duty [N_CH];
  logic [1:0] goal_dir  [N_CH];

  always #5 clk = ~clk;

  motor_duty_ramp_driver #(.CHANNELS(N_CH)) DUT (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ramp_result_checker #(.CHANNELS(N_CH)) u_checker (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .results_due(results_due), .fail_count(fail_count)
  );

  initial begin
    #5_000_000;
    $display("tb_motor_duty_ramp_driver failed");
    $finish;
  end

  // receiver stalls in random bursts
  initial begin
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) < idle_pct) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        res_ready <= 1'b1;
      end
    end
  end

  function automatic cmd_item_t mk(input logic [1:0] op, input logic [1:0] ch,
                                   input logic [9:0] duty, input logic [1:0] dir);
    cmd_item_t c;
    c.operation   = op;
    c.channel     = ch;
    c.target_duty = duty;
    c.target_dir  = dir;
    return c;
  endfunction

  function automatic logic [9:0] pick_duty();
    case ($urandom_range(0, 5))
      0:       return 10'd0;
      1:       return FULL_SCALE;
      2:       return 10'($urandom_range(1001, 1023));
      default: return 10'($urandom_range(0, 1000));
    endcase
  endfunction

  // mostly steady ramps per channel toward a goal, with retargets, stops and noise
  function automatic cmd_item_t pick_cmd();
    cmd_item_t c;
    int        r, ch;
    r  = $urandom_range(0, 99);
    ch = $urandom_range(0, N_CH - 1);
    if (r < 6) begin
      c = cmd_item_t'(16'($urandom));
    end else begin
      if ($urandom_range(0, 11) == 0) goal_duty[ch] = pick_duty();
      if ($urandom_range(0, 13) == 0) goal_dir[ch] = 2'($urandom_range(0, 3));
      c.channel     = 2'(ch);
      c.operation   = (r < 72) ? OP_RAMP : (r < 86) ? OP_DIRECT :
                      (r < 95) ? OP_CLEAR : OP_NONE;
      c.target_duty = ($urandom_range(0, 9) == 0) ? stop_now : goal_duty[ch];
      c.target_dir  = goal_dir[ch];
    end
    return c;
  endfunction

  task automatic send_cmd(input cmd_item_t c);
    if ($urandom_range(0, 99) < idle_pct) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    cmd       <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!cmd_ready);
  endtask

  // let the block go idle: everything delivered, then the pipeline latency
  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [9:0] up, input logic [9:0] down,
                            input logic [3:0] fast, input logic [9:0] thr,
                            input logic [9:0] stop);
    reg_write(REG_UP_STEP, 32'(up));
    reg_write(REG_DOWN_STEP, 32'(down));
    reg_write(REG_FAST, 32'(fast));
    reg_write(REG_THRESHOLD, 32'(thr));
    reg_write(REG_STOP_CODE, 32'(stop));
    stop_now = stop;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed items under reset settings
    idle_pct = 20;
    send_cmd(mk(OP_DIRECT, 2'd0, 10'd1000, DIR_FWD));
    send_cmd(mk(OP_DIRECT, 2'd1, 10'd0,    DIR_BACK));
    send_cmd(mk(OP_DIRECT, 2'd2, 10'd1023, DIR_BACK));
    send_cmd(mk(OP_DIRECT, 2'd3, 10'd500,  DIR_BAD));
    send_cmd(mk(OP_DIRECT, 2'd0, 10'd300,  DIR_BRAKE));
    send_cmd(mk(OP_RAMP,   2'd0, 10'd200,  DIR_FWD));
    send_cmd(mk(OP_RAMP,   2'd0, 10'd200,  DIR_FWD));
    send_cmd(mk(OP_RAMP,   2'd0, 10'd200,  DIR_FWD));
    send_cmd(mk(OP_RAMP,   2'd0, 10'd15,   DIR_FWD));
    send_cmd(mk(OP_RAMP,   2'd0, 10'd1023, DIR_FWD));
    send_cmd(mk(OP_RAMP,   2'd0, 10'd0,    DIR_FWD));
    send_cmd(mk(OP_RAMP,   2'd0, 10'd500,  DIR_BACK));
    send_cmd(mk(OP_RAMP,   2'd1, 10'd800,  DIR_FWD));
    send_cmd(mk(OP_RAMP,   2'd1, 10'd800,  DIR_FWD));
    send_cmd(mk(OP_RAMP,   2'd1, 10'd800,  DIR_BAD));
    send_cmd(mk(OP_RAMP,   2'd2, 10'd600,  DIR_BAD));
    send_cmd(mk(OP_CLEAR,  2'd2, 10'd600,  DIR_FWD));
    send_cmd(mk(OP_NONE,   2'd1, 10'd1023, DIR_BAD));
    send_cmd(mk(OP_CLEAR,  2'd3, 10'd0,    DIR_BRAKE));
    send_cmd(mk(OP_DIRECT, 2'd1, 10'd1000, DIR_FWD));
    send_cmd(mk(OP_DIRECT, 2'd2, 10'd0,    DIR_FWD));
    send_cmd(mk(OP_RAMP,   2'd3, 10'd1023, DIR_BACK));
    drain();

    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin
          set_config(10'd25, 10'd40, 4'd3, 10'd100, 10'd500);
          idle_pct = 30;
        end
        1: begin
          set_config(10'd1000, 10'd1000, 4'd15, 10'd1000, 10'd1000);
          idle_pct = 10;
        end
        2: begin
          // zero factor: stops and reversals do not slow down
          set_config(10'd0, 10'd0, 4'd0, 10'd0, 10'd0);
          idle_pct = 60;
        end
        3: begin
          set_config(10'd1023, 10'd1023, 4'd15, 10'd1023, 10'd1023);
          idle_pct = 0;
        end
        4: begin
          set_config(10'($urandom), 10'($urandom), 4'($urandom),
                     10'($urandom), 10'($urandom));
          idle_pct = 30;
        end
        5: begin
          set_config(10'd1, 10'd2, 4'd1, 10'd5, 10'd999);
          idle_pct = 10;
        end
        default: begin
          set_config(10'($urandom_range(1, 200)), 10'($urandom_range(1, 200)),
                     4'($urandom_range(1, 15)), 10'($urandom_range(0, 1000)),
                     10'($urandom_range(0, 1000)));
          idle_pct = 0;
        end
      endcase
      for (int ch = 0; ch < N_CH; ch++) begin
        goal_duty[ch] = pick_duty();
        goal_dir[ch]  = 2'($urandom_range(1, 2));
      end
      repeat (130) send_cmd(pick_cmd());
      drain();
    end

    if (fail_count == 0) begin
      $display("tb_motor_duty_ramp_driver passed");
    end else begin
      $display("tb_motor_duty_ramp_driver failed");
    end
    $finish;
  end

endmodule

// ----- motor_duty_ramp_driver.f -----
hw/rtl/dmr_pkg.sv
hw/rtl/dmr_cfg.sv
hw/rtl/dmr_ramp.sv
hw/rtl/motor_duty_ramp_driver.sv
bench/ramp_result_checker.sv
bench/tb_motor_duty_ramp_driver.sv
